// ===== design/kpd_pkg.sv =====
package kpd_pkg;

   // Geometry and anchor layout
   localparam int GRID_WIDTH        = 416;
   localparam int GRID_HEIGHT       = 416;
   localparam int COLOR_COUNT       = 2;
   localparam int CLASS_COUNT       = 2;
   localparam int POINT_COUNT       = 5;
   localparam int SCORE_INDEX       = 2 * POINT_COUNT;
   localparam int COLOR_BASE        = SCORE_INDEX + 1;
   localparam int CLASS_BASE        = COLOR_BASE + COLOR_COUNT;
   localparam int VALUES_PER_ANCHOR = CLASS_BASE + CLASS_COUNT;
   localparam int SLOT_W            = $clog2(VALUES_PER_ANCHOR);

   localparam int CELL_COL_W = $clog2(GRID_WIDTH / 8);
   localparam int CELL_ROW_W = $clog2(GRID_HEIGHT / 8);

   // Field widths
   localparam int VALUE_W  = 16;
   localparam int FIX_W    = 32;
   localparam int POINT_W  = 3;
   localparam int ANCHOR_W = 12;
   localparam int ARG_W    = 3;
   localparam int CSR_IDX_W = 3;

   // Datapath widths: value + cell*256 fits 17 bits, then << (8 + log2 stride)
   localparam int SUM_W       = 17;
   localparam int COORD_SHIFT = 11;
   localparam int COORD_W     = SUM_W + COORD_SHIFT + 2;
   localparam int PROD_W      = FIX_W + COORD_W;
   localparam int ACC_W       = 64;
   localparam int FRAC_BITS   = 16;
   localparam int ROUND_HALF  = 32768;

   localparam int JOB_QUEUE_DEPTH = 2;
   localparam int QPTR_W          = $clog2(JOB_QUEUE_DEPTH);
   localparam int QCNT_W          = $clog2(JOB_QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      LEVEL_S8,
      LEVEL_S16,
      LEVEL_S32
   } level_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCORE_THRESHOLD,
      CSR_MAT_XX,
      CSR_MAT_XY,
      CSR_MAT_XT,
      CSR_MAT_YX,
      CSR_MAT_YY,
      CSR_MAT_YT
   } csr_index_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] feature_value;
      logic                      frame_start;
   } req_type;

   typedef struct packed {
      logic signed [FIX_W-1:0]   point_x;
      logic signed [FIX_W-1:0]   point_y;
      logic [POINT_W-1:0]        point_number;
      logic [ANCHOR_W-1:0]       anchor_number;
      logic                      class_id;
      logic                      color_id;
      logic signed [VALUE_W-1:0] score;
      logic                      last_point;
   } rsp_type;

   typedef struct packed {
      logic signed [FIX_W-1:0] xx;
      logic signed [FIX_W-1:0] xy;
      logic signed [FIX_W-1:0] xt;
      logic signed [FIX_W-1:0] yx;
      logic signed [FIX_W-1:0] yy;
      logic signed [FIX_W-1:0] yt;
   } affine_type;

   // One passing anchor handed from front to back
   typedef struct packed {
      logic [POINT_COUNT-1:0][VALUE_W-1:0] pt_x;
      logic [POINT_COUNT-1:0][VALUE_W-1:0] pt_y;
      logic [CELL_COL_W-1:0]               cell_col;
      logic [CELL_ROW_W-1:0]               cell_row;
      level_type                           level;
      logic [ANCHOR_W-1:0]                 anchor_number;
      logic                                class_id;
      logic                                color_id;
      logic signed [VALUE_W-1:0]           score;
   } job_type;

   // Side fields that ride along the back pipeline
   typedef struct packed {
      logic [POINT_W-1:0]        point_number;
      logic [ANCHOR_W-1:0]       anchor_number;
      logic                      class_id;
      logic                      color_id;
      logic signed [VALUE_W-1:0] score;
      logic                      last_point;
   } meta_type;

   function automatic logic [CELL_COL_W-1:0] last_col(input level_type level);
      logic [CELL_COL_W-1:0] r;
      case (level)
         LEVEL_S16: r = CELL_COL_W'(GRID_WIDTH / 16 - 1);
         LEVEL_S32: r = CELL_COL_W'(GRID_WIDTH / 32 - 1);
         default:   r = CELL_COL_W'(GRID_WIDTH / 8 - 1);
      endcase
      return r;
   endfunction

   function automatic logic [CELL_ROW_W-1:0] last_row(input level_type level);
      logic [CELL_ROW_W-1:0] r;
      case (level)
         LEVEL_S16: r = CELL_ROW_W'(GRID_HEIGHT / 16 - 1);
         LEVEL_S32: r = CELL_ROW_W'(GRID_HEIGHT / 32 - 1);
         default:   r = CELL_ROW_W'(GRID_HEIGHT / 8 - 1);
      endcase
      return r;
   endfunction

endpackage

// ===== design/kpd_front.sv =====
module kpd_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  kpd_pkg::req_type             req_data,
   input  logic signed [kpd_pkg::VALUE_W-1:0] score_threshold,
   input  logic                         q_full,
   output logic                         q_push,
   output kpd_pkg::job_type             q_job
);

   logic [kpd_pkg::SLOT_W-1:0]     slot_ff, slot_in;
   logic [kpd_pkg::ANCHOR_W-1:0]   anchor_ff, anchor_in;
   logic [kpd_pkg::CELL_COL_W-1:0] col_ff, col_in;
   logic [kpd_pkg::CELL_ROW_W-1:0] row_ff, row_in;
   kpd_pkg::level_type             level_ff, level_in;
   logic signed [kpd_pkg::VALUE_W-1:0] vals_ff [kpd_pkg::VALUES_PER_ANCHOR];

   logic signed [kpd_pkg::VALUE_W-1:0] cur [kpd_pkg::VALUES_PER_ANCHOR];
   logic [kpd_pkg::SLOT_W-1:0]     slot;
   logic [kpd_pkg::ANCHOR_W-1:0]   anchor;
   logic [kpd_pkg::CELL_COL_W-1:0] col;
   logic [kpd_pkg::CELL_ROW_W-1:0] row;
   kpd_pkg::level_type             level;
   logic                           accept;
   logic                           anchor_done;
   logic [kpd_pkg::ARG_W-1:0]      color_idx;
   logic [kpd_pkg::ARG_W-1:0]      class_idx;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   // frame_start restarts the counters before this value is placed
   always_comb begin
      slot   = req_data.frame_start ? '0 : slot_ff;
      anchor = req_data.frame_start ? '0 : anchor_ff;
      col    = req_data.frame_start ? '0 : col_ff;
      row    = req_data.frame_start ? '0 : row_ff;
      level  = req_data.frame_start ? kpd_pkg::LEVEL_S8 : level_ff;
   end

   assign anchor_done = accept &&
                        (slot == kpd_pkg::SLOT_W'(kpd_pkg::VALUES_PER_ANCHOR - 1));

   always_comb begin
      for (int i = 0; i < kpd_pkg::VALUES_PER_ANCHOR; i++) begin
         cur[i] = (slot == kpd_pkg::SLOT_W'(i)) ? req_data.feature_value : vals_ff[i];
      end
   end

   // Argmax, lowest index wins ties
   always_comb begin
      logic signed [kpd_pkg::VALUE_W-1:0] best_color;
      logic signed [kpd_pkg::VALUE_W-1:0] best_class;
      best_color = cur[kpd_pkg::COLOR_BASE];
      best_class = cur[kpd_pkg::CLASS_BASE];
      color_idx  = '0;
      class_idx  = '0;
      for (int i = 1; i < kpd_pkg::COLOR_COUNT; i++) begin
         if (cur[kpd_pkg::COLOR_BASE + i] > best_color) begin
            best_color = cur[kpd_pkg::COLOR_BASE + i];
            color_idx  = kpd_pkg::ARG_W'(i);
         end
      end
      for (int i = 1; i < kpd_pkg::CLASS_COUNT; i++) begin
         if (cur[kpd_pkg::CLASS_BASE + i] > best_class) begin
            best_class = cur[kpd_pkg::CLASS_BASE + i];
            class_idx  = kpd_pkg::ARG_W'(i);
         end
      end
   end

   always_comb begin
      for (int p = 0; p < kpd_pkg::POINT_COUNT; p++) begin
         q_job.pt_x[p] = cur[2 * p];
         q_job.pt_y[p] = cur[2 * p + 1];
      end
      q_job.cell_col      = col;
      q_job.cell_row      = row;
      q_job.level         = level;
      q_job.anchor_number = anchor;
      q_job.class_id      = class_idx[0];
      q_job.color_id      = color_idx[0];
      q_job.score         = cur[kpd_pkg::SCORE_INDEX];
   end

   assign q_push = anchor_done && (cur[kpd_pkg::SCORE_INDEX] >= score_threshold);

   always_comb begin
      slot_in   = slot_ff;
      anchor_in = anchor_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      level_in  = level_ff;
      if (accept) begin
         slot_in   = slot + 1'b1;
         anchor_in = anchor;
         col_in    = col;
         row_in    = row;
         level_in  = level;
         if (anchor_done) begin
            slot_in   = '0;
            anchor_in = anchor + 1'b1;
            col_in    = col + 1'b1;
            if (col == kpd_pkg::last_col(level)) begin
               col_in = '0;
               row_in = row + 1'b1;
               if (row == kpd_pkg::last_row(level)) begin
                  row_in = '0;
                  case (level)
                     kpd_pkg::LEVEL_S8:  level_in = kpd_pkg::LEVEL_S16;
                     kpd_pkg::LEVEL_S16: level_in = kpd_pkg::LEVEL_S32;
                     default: begin
                        // end of frame: wrap to the first anchor
                        level_in  = kpd_pkg::LEVEL_S8;
                        anchor_in = '0;
                     end
                  endcase
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff   <= '0;
         anchor_ff <= '0;
         col_ff    <= '0;
         row_ff    <= '0;
         level_ff  <= kpd_pkg::LEVEL_S8;
      end else begin
         slot_ff   <= slot_in;
         anchor_ff <= anchor_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         vals_ff[slot] <= req_data.feature_value;
      end
   end

endmodule

// ===== design/kpd_job_fifo.sv =====
module kpd_job_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  kpd_pkg::job_type push_job,
   input  logic             pop,
   output kpd_pkg::job_type head_job,
   output logic             empty,
   output logic             full
);

   kpd_pkg::job_type            entry_ff [kpd_pkg::JOB_QUEUE_DEPTH];
   logic [kpd_pkg::QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [kpd_pkg::QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [kpd_pkg::QCNT_W-1:0]  count_ff, count_in;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == kpd_pkg::QCNT_W'(kpd_pkg::JOB_QUEUE_DEPTH));
   assign head_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == kpd_pkg::QPTR_W'(kpd_pkg::JOB_QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == kpd_pkg::QPTR_W'(kpd_pkg::JOB_QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== design/kpd_back.sv =====
module kpd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  kpd_pkg::job_type    q_job,
   output logic                q_pop,
   input  kpd_pkg::affine_type mat,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output kpd_pkg::rsp_type    rsp_data
);

   localparam int SH_W = kpd_pkg::ACC_W - kpd_pkg::FRAC_BITS;

   logic [kpd_pkg::POINT_W-1:0] pt_ff, pt_in;

   logic                                  st1_valid_ff;
   kpd_pkg::meta_type                     st1_meta_ff;
   logic signed [kpd_pkg::COORD_W-1:0]    st1_x_ff, st1_y_ff;

   logic                                  st2_valid_ff;
   kpd_pkg::meta_type                     st2_meta_ff;
   logic signed [kpd_pkg::PROD_W-1:0]     st2_xx_ff, st2_xy_ff, st2_yx_ff, st2_yy_ff;

   logic                                  st3_valid_ff;
   kpd_pkg::meta_type                     st3_meta_ff;
   logic signed [kpd_pkg::ACC_W-1:0]      st3_ax_ff, st3_ay_ff;

   logic                                  out_valid_ff;
   kpd_pkg::meta_type                     out_meta_ff;
   logic signed [kpd_pkg::FIX_W-1:0]      out_x_ff, out_y_ff;

   logic                                  advance;
   logic                                  issue;
   logic                                  last_pt;
   logic signed [kpd_pkg::VALUE_W-1:0]    vx, vy;
   logic signed [kpd_pkg::SUM_W-1:0]      sum_x, sum_y;
   logic signed [kpd_pkg::COORD_W-1:0]    coord_x, coord_y;
   logic [4:0]                            shamt;
   kpd_pkg::meta_type                     issue_meta;
   logic signed [kpd_pkg::ACC_W-1:0]      acc_x, acc_y;

   function automatic logic signed [kpd_pkg::FIX_W-1:0] saturate(
      input logic signed [kpd_pkg::ACC_W-1:0] acc);
      logic [SH_W-1:0] sh;
      logic signed [kpd_pkg::FIX_W-1:0] r;
      sh = acc[kpd_pkg::ACC_W-1:kpd_pkg::FRAC_BITS];
      if ((&sh[SH_W-1:kpd_pkg::FIX_W-1]) || !(|sh[SH_W-1:kpd_pkg::FIX_W-1])) begin
         r = sh[kpd_pkg::FIX_W-1:0];
      end else if (sh[SH_W-1]) begin
         r = {1'b1, {(kpd_pkg::FIX_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(kpd_pkg::FIX_W-1){1'b1}}};
      end
      return r;
   endfunction

   // Whole pipeline moves together; it holds only while the output is stalled
   assign advance = !out_valid_ff || rsp_ready;
   assign issue   = advance && !q_empty;
   assign last_pt = (pt_ff == kpd_pkg::POINT_W'(kpd_pkg::POINT_COUNT - 1));
   assign q_pop   = issue && last_pt;

   // Coordinate in signed Q14.16: (v + 256*cell) << (8 + log2 stride)
   always_comb begin
      vx    = q_job.pt_x[pt_ff];
      vy    = q_job.pt_y[pt_ff];
      sum_x = kpd_pkg::SUM_W'(vx) + kpd_pkg::SUM_W'({q_job.cell_col, 8'b0});
      sum_y = kpd_pkg::SUM_W'(vy) + kpd_pkg::SUM_W'({q_job.cell_row, 8'b0});
      case (q_job.level)
         kpd_pkg::LEVEL_S16: shamt = 5'(kpd_pkg::COORD_SHIFT + 1);
         kpd_pkg::LEVEL_S32: shamt = 5'(kpd_pkg::COORD_SHIFT + 2);
         default:            shamt = 5'(kpd_pkg::COORD_SHIFT);
      endcase
      coord_x = kpd_pkg::COORD_W'(sum_x) <<< shamt;
      coord_y = kpd_pkg::COORD_W'(sum_y) <<< shamt;

      issue_meta.point_number  = pt_ff;
      issue_meta.anchor_number = q_job.anchor_number;
      issue_meta.class_id      = q_job.class_id;
      issue_meta.color_id      = q_job.color_id;
      issue_meta.score         = q_job.score;
      issue_meta.last_point    = last_pt;
   end

   always_comb begin
      pt_in = pt_ff;
      if (issue) begin
         pt_in = last_pt ? '0 : pt_ff + 1'b1;
      end
   end

   // Round to nearest, ties up, after summing the two products and translation
   always_comb begin
      acc_x = kpd_pkg::ACC_W'(st2_xx_ff) + kpd_pkg::ACC_W'(st2_xy_ff)
            + kpd_pkg::ACC_W'($signed({mat.xt, 16'b0}))
            + kpd_pkg::ACC_W'(kpd_pkg::ROUND_HALF);
      acc_y = kpd_pkg::ACC_W'(st2_yx_ff) + kpd_pkg::ACC_W'(st2_yy_ff)
            + kpd_pkg::ACC_W'($signed({mat.yt, 16'b0}))
            + kpd_pkg::ACC_W'(kpd_pkg::ROUND_HALF);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pt_ff        <= '0;
         st1_valid_ff <= 1'b0;
         st2_valid_ff <= 1'b0;
         st3_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         pt_ff <= pt_in;
         if (advance) begin
            st1_valid_ff <= issue;
            st2_valid_ff <= st1_valid_ff;
            st3_valid_ff <= st2_valid_ff;
            out_valid_ff <= st3_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         st1_meta_ff <= issue_meta;
         st1_x_ff    <= coord_x;
         st1_y_ff    <= coord_y;

         st2_meta_ff <= st1_meta_ff;
         st2_xx_ff   <= $signed(mat.xx) * st1_x_ff;
         st2_xy_ff   <= $signed(mat.xy) * st1_y_ff;
         st2_yx_ff   <= $signed(mat.yx) * st1_x_ff;
         st2_yy_ff   <= $signed(mat.yy) * st1_y_ff;

         st3_meta_ff <= st2_meta_ff;
         st3_ax_ff   <= acc_x;
         st3_ay_ff   <= acc_y;

         out_meta_ff <= st3_meta_ff;
         out_x_ff    <= saturate(st3_ax_ff);
         out_y_ff    <= saturate(st3_ay_ff);
      end
   end

   assign rsp_valid = out_valid_ff;

   always_comb begin
      rsp_data.point_x       = out_x_ff;
      rsp_data.point_y       = out_y_ff;
      rsp_data.point_number  = out_meta_ff.point_number;
      rsp_data.anchor_number = out_meta_ff.anchor_number;
      rsp_data.class_id      = out_meta_ff.class_id;
      rsp_data.color_id      = out_meta_ff.color_id;
      rsp_data.score         = out_meta_ff.score;
      rsp_data.last_point    = out_meta_ff.last_point;
   end

endmodule

// ===== design/keypoint_proposal_decoder_unit.sv =====
// Throughput: one request per cycle while the job queue is not full; each anchor takes
// fifteen requests, and a passing anchor gives five results from a four-stage point
// pipeline (coordinate, multiply, sum, round/saturate) that holds while rsp is stalled.
// Path to rsp: job queue, then stages st1, st2, st3 and the output register.
// Reset (synchronous): counters, job queue and pipeline cleared; threshold 154,
// identity matrix. No clearing pass.
module keypoint_proposal_decoder_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  kpd_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output kpd_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [kpd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [kpd_pkg::FIX_W-1:0]         csr_data
);

   logic signed [kpd_pkg::VALUE_W-1:0] threshold_ff, threshold_in;
   kpd_pkg::affine_type                mat_ff, mat_in;

   logic             q_push, q_pop, q_empty, q_full;
   kpd_pkg::job_type push_job, head_job;

   assign csr_ready = 1'b1;

   always_comb begin
      threshold_in = threshold_ff;
      mat_in       = mat_ff;
      if (csr_valid) begin
         case (csr_index)
            kpd_pkg::CSR_SCORE_THRESHOLD: threshold_in = csr_data[kpd_pkg::VALUE_W-1:0];
            kpd_pkg::CSR_MAT_XX:          mat_in.xx    = csr_data;
            kpd_pkg::CSR_MAT_XY:          mat_in.xy    = csr_data;
            kpd_pkg::CSR_MAT_XT:          mat_in.xt    = csr_data;
            kpd_pkg::CSR_MAT_YX:          mat_in.yx    = csr_data;
            kpd_pkg::CSR_MAT_YY:          mat_in.yy    = csr_data;
            kpd_pkg::CSR_MAT_YT:          mat_in.yt    = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= kpd_pkg::VALUE_W'(154);
         mat_ff.xx    <= kpd_pkg::FIX_W'(65536);
         mat_ff.xy    <= '0;
         mat_ff.xt    <= '0;
         mat_ff.yx    <= '0;
         mat_ff.yy    <= kpd_pkg::FIX_W'(65536);
         mat_ff.yt    <= '0;
      end else begin
         threshold_ff <= threshold_in;
         mat_ff       <= mat_in;
      end
   end

   kpd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .score_threshold (threshold_ff),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_job           (push_job)
   );

   kpd_job_fifo u_job_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head_job (head_job),
      .empty    (q_empty),
      .full     (q_full)
   );

   kpd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_job     (head_job),
      .q_pop     (q_pop),
      .mat       (mat_ff),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
